/* hdl/bcf_pkg.sv */
// Shared constants, types and state codes for the biquad cascade filter.
package bcf_pkg;

	localparam int MAX_SECTIONS = 8;
	localparam int TAPS         = 5;
	localparam int NUM_COEFS    = TAPS * MAX_SECTIONS;
	localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int COEF_AW      = $clog2(NUM_COEFS);
	localparam int DATA_W       = 32;
	localparam int ACC_W        = 2 * DATA_W + 2;
	localparam int FRAC_W       = 30;

	localparam logic FUNC_FILTER = 1'b0;
	localparam logic FUNC_COEF   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		TAP_B0,
		TAP_B1,
		TAP_B2,
		TAP_A1,
		TAP_A2
	} tap_t;

	typedef struct packed {
		logic vld;
		logic neg;
		logic clr;
	} mac_ctl_t;

endpackage

/* hdl/bcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bcf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/bcf_mac.sv */
// Shared multiply-accumulate unit with Q2.30 rounding and 32-bit saturation.
module bcf_mac import bcf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] coef,
	input  logic signed [DATA_W-1:0] opnd,
	output logic                     busy,
	output logic signed [DATA_W-1:0] result
);

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);

	logic signed [2*DATA_W-1:0] prod_s2;
	logic                       vld_s2;
	logic                       neg_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s2 <= coef * opnd;
			neg_s2  <= ctl.neg;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= neg_s2 ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end
	end

	assign prod_ext = ACC_W'(prod_s2);

	// Floor of (sum + half) / 2^30: halves round toward plus infinity.
	always_comb begin
		rnd     = acc_q + HALF;
		shifted = rnd >>> FRAC_W;
		if (shifted > SAT_HI) begin
			result = SAT_HI[DATA_W-1:0];
		end else if (shifted < SAT_LO) begin
			result = SAT_LO[DATA_W-1:0];
		end else begin
			result = shifted[DATA_W-1:0];
		end
	end

	assign busy = vld_s2;

endmodule

/* hdl/biquad_cascade_iir_filter_unit.sv */
// Top level of the direct form I biquad cascade filter with shared MAC.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-------------------------------------
//  cfg      | in        | cfg_we (no stall)             | cfg_wdata = num_sections
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata, tuser (filter or coef beat)
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata = sample_out
//
// A coefficient beat is written straight into the RAM from idle. A filter beat issues
// five MAC operations per active section, then drains the RAM read and multiply stages,
// and finally hands the result to the output register; a new beat is taken only in idle.
// The single shared multiplier and the one coefficient RAM read port serialize the taps.
// Reset clears the section history, num_sections and all handshake state; coefficients
// are undefined until written. A full output register holds the block in its output
// state, and s_axis_tready stays low until the result moves into it.
module biquad_cascade_iir_filter_unit import bcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,      // num_sections
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // sample_in[31:0], coef_index[37:32], coef_value[69:38]
	input  logic [1:0]  s_axis_tuser,   // func[0], first_sample[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // sample_out[31:0]
);

	state_t                     state_q, state_d;
	logic [3:0]                 num_sec_q;
	logic signed [DATA_W-1:0]   x_q;
	logic signed [DATA_W-1:0]   res_q;
	logic [SEC_W-1:0]           sec_q;
	logic [SEC_W-1:0]           last_q;
	tap_t                       tap_q;
	logic [COEF_AW-1:0]         base_q;
	logic                       v_s1;
	tap_t                       tap_s1;
	logic                       out_vld_q;
	logic signed [DATA_W-1:0]   out_data_q;

	logic signed [DATA_W-1:0]   hist_in1_q  [MAX_SECTIONS];
	logic signed [DATA_W-1:0]   hist_in2_q  [MAX_SECTIONS];
	logic signed [DATA_W-1:0]   hist_out1_q [MAX_SECTIONS];
	logic signed [DATA_W-1:0]   hist_out2_q [MAX_SECTIONS];

	logic                       func;
	logic                       first_sample;
	logic signed [DATA_W-1:0]   sample_in;
	logic [5:0]                 coef_index;
	logic signed [DATA_W-1:0]   coef_value;

	logic                       accept;
	logic                       start;
	logic                       coef_we;
	logic                       rd_en;
	logic                       sec_done;
	logic                       out_load;
	logic                       no_sections;
	logic [SEC_W-1:0]           last_sec;
	logic [COEF_AW-1:0]         rd_addr;
	logic [DATA_W-1:0]          coef_rdata;
	logic signed [DATA_W-1:0]   opnd;
	logic signed [DATA_W-1:0]   y;
	logic                       mac_busy;
	mac_ctl_t                   mac_ctl;

	// Unpack the input beat.
	assign func         = s_axis_tuser[0];
	assign first_sample = s_axis_tuser[1];
	assign sample_in    = s_axis_tdata[31:0];
	assign coef_index   = s_axis_tdata[37:32];
	assign coef_value   = s_axis_tdata[69:38];

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign coef_we = accept && (func == FUNC_COEF) && (32'(coef_index) < NUM_COEFS);

	// Clamp the section count to the hardware depth; keep the index of the last one.
	assign no_sections = (num_sec_q == '0);
	assign last_sec    = (32'(num_sec_q) > MAX_SECTIONS) ? SEC_W'(MAX_SECTIONS - 1)
	                                                     : SEC_W'(num_sec_q - 4'd1);

	// Sequencer: five taps per section, drain the MAC, retire it; then load the output.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		start         = 1'b0;
		rd_en         = 1'b0;
		sec_done      = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept && (func == FUNC_FILTER)) begin
					start   = 1'b1;
					state_d = no_sections ? ST_OUT : ST_MAC;
				end
			end
			ST_MAC: begin
				rd_en = 1'b1;
				if (tap_q == TAP_A2) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !mac_busy) begin
					sec_done = 1'b1;
					state_d  = (sec_q == last_q) ? ST_OUT : ST_MAC;
				end
			end
			ST_OUT: begin
				if (!out_vld_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sec_q <= '0;
		end else if (cfg_we) begin
			num_sec_q <= cfg_wdata;
		end
	end

	// Tap counter and read-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= TAP_B0;
			v_s1   <= 1'b0;
			tap_s1 <= TAP_B0;
		end else begin
			v_s1   <= rd_en;
			tap_s1 <= tap_q;
			if (start || sec_done) begin
				tap_q <= TAP_B0;
			end else if (rd_en && (tap_q != TAP_A2)) begin
				tap_q <= tap_t'(tap_q + 3'd1);
			end
		end
	end

	// Section walk: current input, section index and coefficient base.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= sample_in;
			res_q  <= '0;
			sec_q  <= '0;
			base_q <= '0;
			last_q <= last_sec;
		end else if (sec_done) begin
			x_q    <= y;
			res_q  <= y;
			sec_q  <= sec_q + SEC_W'(1);
			base_q <= base_q + COEF_AW'(TAPS);
		end
	end

	// Section history: clear on reset and first sample, shift on section retire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				hist_in1_q[i]  <= '0;
				hist_in2_q[i]  <= '0;
				hist_out1_q[i] <= '0;
				hist_out2_q[i] <= '0;
			end
		end else if (start && first_sample) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				hist_in1_q[i]  <= '0;
				hist_in2_q[i]  <= '0;
				hist_out1_q[i] <= '0;
				hist_out2_q[i] <= '0;
			end
		end else if (sec_done) begin
			hist_in2_q[sec_q]  <= hist_in1_q[sec_q];
			hist_in1_q[sec_q]  <= x_q;
			hist_out2_q[sec_q] <= hist_out1_q[sec_q];
			hist_out1_q[sec_q] <= y;
		end
	end

	assign rd_addr = base_q + COEF_AW'(tap_q);

	bcf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NUM_COEFS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (COEF_AW'(coef_index)),
		.wdata (coef_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (coef_rdata)
	);

	// Pick the data operand that pairs with the coefficient just read.
	always_comb begin
		case (tap_s1)
			TAP_B0:  opnd = x_q;
			TAP_B1:  opnd = hist_in1_q[sec_q];
			TAP_B2:  opnd = hist_in2_q[sec_q];
			TAP_A1:  opnd = hist_out1_q[sec_q];
			TAP_A2:  opnd = hist_out2_q[sec_q];
			default: opnd = '0;
		endcase
	end

	// Feedback taps subtract.
	assign mac_ctl.vld = v_s1;
	assign mac_ctl.neg = (tap_s1 == TAP_A1) || (tap_s1 == TAP_A2);
	assign mac_ctl.clr = start || sec_done;

	bcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_rdata),
		.opnd   (opnd),
		.busy   (mac_busy),
		.result (y)
	);

	// Output register: hold the beat until taken, load when free or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_coef_beat_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_COEF)) |=> (state_q == ST_IDLE))
		else $error("coefficient beat started a filter run");

	a_section_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MAC) || (state_q == ST_DRAIN)) |-> (sec_q <= last_q))
		else $error("section index ran past the last active section");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("pending result overwrote a stalled output beat");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sec_done |-> (!v_s1 && !mac_busy && !rd_en))
		else $error("section retired with products still in flight");
`endif

endmodule
